// ----- rtl/core/tlpt_pkg.sv -----
// Shared types and constants of the two-level page table.
package tlpt_pkg;

    // Field widths of the request and response beats
    localparam int REQ_TYPE_W = 2;
    localparam int VPAGE_W    = 21;
    localparam int FRAME_W    = 21;

    // Virtual page split: upper bits pick the first level, lower bits the second
    localparam int L2_IDX_W   = 10;
    localparam int L1_IDX_W   = VPAGE_W - L2_IDX_W;
    localparam int L1_ENTRIES = 1 << L1_IDX_W;
    localparam int L2_ENTRIES = 1 << L2_IDX_W;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd2;

    // Walk sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_L1,
        ST_L2
    } state_t;

endpackage

// ----- rtl/core/tlpt_if.sv -----
// Request and response channel interfaces of the page table.
interface tlpt_req_if
    import tlpt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [VPAGE_W-1:0]    vpage;
    logic [FRAME_W-1:0]    pframe;

    modport source (output valid, req_type, vpage, pframe, input ready);
    modport sink   (input valid, req_type, vpage, pframe, output ready);
endinterface

interface tlpt_rsp_if
    import tlpt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame;
    logic               fault;
    logic               table_full;

    modport source (output valid, frame, fault, table_full, input ready);
    modport sink   (input valid, frame, fault, table_full, output ready);
endinterface

// ----- rtl/core/tlpt_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/tlpt_sweep.sv -----
// Post-reset clearing sweep: walks every memory address once.
module tlpt_sweep #(
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     rst_n,
    output logic                     busy,
    output logic [$clog2(DEPTH)-1:0] addr
);

    localparam int AW = $clog2(DEPTH);

    logic          busy_reg;
    logic          busy_next;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;

    // Advance one address a cycle until the last one is written
    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg)
        begin
            if (addr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign busy = busy_reg;
    assign addr = addr_reg;

endmodule

// ----- rtl/core/two_level_page_table_core.sv -----
// Top level of the two-level page table: walk sequencer and table memories.
//
//  channel  dir  handshake          payload
//  req      in   req.valid/ready    req_type, vpage, pframe
//  rsp      out  rsp.valid/ready    frame, fault, table_full
//
// Update, clear and a lookup that misses the first level retire from state ST_L1;
// a lookup that hits the first level goes on to ST_L2 and retires there, after the two
// dependent registered reads of the first-level and second-level RAMs.
// After reset a clearing sweep over max(2048, POOL_TABLES*1024) addresses zeroes
// both RAMs; req.ready stays low during it.
// A stalled rsp holds its beat; a finished walk waits in its state until the
// output register is free, and the next request is taken in the same cycle.
module two_level_page_table_core
    import tlpt_pkg::*;
#(
    parameter int POOL_TABLES = 16,
    parameter int FRAME_BITS  = 21
) (
    input  logic       clk,
    input  logic       rst_n,
    tlpt_req_if.sink   req,
    tlpt_rsp_if.source rsp
);

    localparam int SLOT_W      = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int USED_W      = $clog2(POOL_TABLES + 1);
    localparam int L1_W        = 1 + SLOT_W;
    localparam int L2_W        = 1 + FRAME_BITS;
    localparam int L2_DEPTH    = POOL_TABLES * L2_ENTRIES;
    localparam int L2_AW       = $clog2(L2_DEPTH);
    localparam int SWEEP_DEPTH = (L2_DEPTH > L1_ENTRIES) ? L2_DEPTH : L1_ENTRIES;
    localparam int SWEEP_AW    = $clog2(SWEEP_DEPTH);

    // Clearing sweep
    logic                sweep_busy;
    logic [SWEEP_AW-1:0] sweep_addr;

    tlpt_sweep #(
        .DEPTH (SWEEP_DEPTH)
    ) u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (sweep_busy),
        .addr  (sweep_addr)
    );

    // Memory ports
    logic                l1_wr_en;
    logic [L1_IDX_W-1:0] l1_wr_addr;
    logic [L1_W-1:0]     l1_wr_data;
    logic                l1_rd_en;
    logic [L1_IDX_W-1:0] l1_rd_addr;
    logic [L1_W-1:0]     l1_rd_data;
    logic                l2_wr_en;
    logic [L2_AW-1:0]    l2_wr_addr;
    logic [L2_W-1:0]     l2_wr_data;
    logic                l2_rd_en;
    logic [L2_AW-1:0]    l2_rd_addr;
    logic [L2_W-1:0]     l2_rd_data;

    // Walk-side write requests, merged with the sweep below
    logic                wk_l1_wr_en;
    logic [L1_W-1:0]     wk_l1_wr_data;
    logic                wk_l2_wr_en;
    logic [L2_AW-1:0]    wk_l2_wr_addr;
    logic [L2_W-1:0]     wk_l2_wr_data;

    tlpt_ram #(
        .WIDTH (L1_W),
        .DEPTH (L1_ENTRIES)
    ) u_l1_ram (
        .clk     (clk),
        .wr_en   (l1_wr_en),
        .wr_addr (l1_wr_addr),
        .wr_data (l1_wr_data),
        .rd_en   (l1_rd_en),
        .rd_addr (l1_rd_addr),
        .rd_data (l1_rd_data)
    );

    tlpt_ram #(
        .WIDTH (L2_W),
        .DEPTH (L2_DEPTH)
    ) u_l2_ram (
        .clk     (clk),
        .wr_en   (l2_wr_en),
        .wr_addr (l2_wr_addr),
        .wr_data (l2_wr_data),
        .rd_en   (l2_rd_en),
        .rd_addr (l2_rd_addr),
        .rd_data (l2_rd_data)
    );

    // Sequencer and request registers
    state_t                state_reg;
    state_t                state_next;
    logic [REQ_TYPE_W-1:0] type_reg;
    logic [L1_IDX_W-1:0]   i1_reg;
    logic [L2_IDX_W-1:0]   i2_reg;
    logic [FRAME_W-1:0]    pframe_reg;
    logic [USED_W-1:0]     used_reg;
    logic [USED_W-1:0]     used_next;

    // First-level forwarding across a same-edge write and read
    logic                  fwd_valid_reg;
    logic                  fwd_valid_next;
    logic [L1_IDX_W-1:0]   fwd_idx_reg;
    logic [L1_W-1:0]       fwd_data_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [FRAME_W-1:0]    out_frame_reg;
    logic                  out_fault_reg;
    logic                  out_full_reg;

    logic                  accept;
    logic                  out_free;
    logic                  done;
    logic                  load;
    logic [FRAME_W-1:0]    res_frame;
    logic                  res_fault;
    logic                  res_full;
    logic [L1_W-1:0]       l1_ent;
    logic                  l1_hit;
    logic [SLOT_W-1:0]     l1_slot;
    logic [SLOT_W-1:0]     new_slot;
    logic                  pool_free;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // Pick up a first-level entry written on the edge that issued our read
    assign l1_ent    = (fwd_valid_reg && (fwd_idx_reg == i1_reg)) ? fwd_data_reg : l1_rd_data;
    assign l1_hit    = l1_ent[SLOT_W];
    assign l1_slot   = l1_ent[SLOT_W-1:0];
    assign new_slot  = SLOT_W'(used_reg);
    assign pool_free = (used_reg < USED_W'(POOL_TABLES));

    // Next state, memory commands and result
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        done          = 1'b0;
        res_frame     = '0;
        res_fault     = 1'b0;
        res_full      = 1'b0;
        wk_l1_wr_en   = 1'b0;
        wk_l1_wr_data = {1'b1, new_slot};
        wk_l2_wr_en   = 1'b0;
        wk_l2_wr_addr = L2_AW'({l1_slot, i2_reg});
        wk_l2_wr_data = {1'b1, FRAME_BITS'(pframe_reg)};
        l2_rd_en      = 1'b0;
        l2_rd_addr    = L2_AW'({l1_slot, i2_reg});

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_L1;
                end
            end
            ST_L1:
            begin
                case (type_reg)
                    REQ_LOOKUP:
                    begin
                        if (l1_hit)
                        begin
                            l2_rd_en   = 1'b1;
                            state_next = ST_L2;
                        end
                        else
                        begin
                            done      = 1'b1;
                            res_fault = 1'b1;
                        end
                    end
                    REQ_UPDATE:
                    begin
                        done = 1'b1;
                        if (l1_hit)
                        begin
                            wk_l2_wr_en = out_free;
                        end
                        else if (pool_free)
                        begin
                            wk_l1_wr_en   = out_free;
                            wk_l2_wr_en   = out_free;
                            wk_l2_wr_addr = L2_AW'({new_slot, i2_reg});
                            if (out_free)
                            begin
                                used_next = used_reg + USED_W'(1);
                            end
                        end
                        else
                        begin
                            res_full = 1'b1;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        done          = 1'b1;
                        wk_l2_wr_en   = out_free && l1_hit;
                        wk_l2_wr_data = '0;
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end
            ST_L2:
            begin
                done      = 1'b1;
                res_fault = !l2_rd_data[FRAME_BITS];
                if (l2_rd_data[FRAME_BITS])
                begin
                    res_frame = FRAME_W'(l2_rd_data[FRAME_BITS-1:0]);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Retire into the output register, take the next request alongside
        if (done && out_free)
        begin
            state_next = accept ? ST_L1 : ST_IDLE;
        end
    end

    assign load      = done && out_free;
    assign req.ready = !sweep_busy && ((state_reg == ST_IDLE) || load);

    // Memory port muxing between sweep and walk
    assign l1_rd_en   = accept;
    assign l1_rd_addr = req.vpage[VPAGE_W-1:L2_IDX_W];
    assign l1_wr_en   = sweep_busy || wk_l1_wr_en;
    assign l1_wr_addr = sweep_busy ? sweep_addr[L1_IDX_W-1:0] : i1_reg;
    assign l1_wr_data = sweep_busy ? '0 : wk_l1_wr_data;
    assign l2_wr_en   = sweep_busy || wk_l2_wr_en;
    assign l2_wr_addr = sweep_busy ? L2_AW'(sweep_addr) : wk_l2_wr_addr;
    assign l2_wr_data = sweep_busy ? '0 : wk_l2_wr_data;

    // Keep the forward until the next first-level read lands clean
    always_comb
    begin
        fwd_valid_next = fwd_valid_reg;
        if (wk_l1_wr_en)
        begin
            fwd_valid_next = 1'b1;
        end
        else if (accept)
        begin
            fwd_valid_next = 1'b0;
        end
    end

    // Drop the output beat when taken, refill on retire
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= req.req_type;
            i1_reg     <= req.vpage[VPAGE_W-1:L2_IDX_W];
            i2_reg     <= req.vpage[L2_IDX_W-1:0];
            pframe_reg <= req.pframe;
        end
        if (wk_l1_wr_en)
        begin
            fwd_idx_reg  <= i1_reg;
            fwd_data_reg <= wk_l1_wr_data;
        end
        if (load)
        begin
            out_frame_reg <= res_frame;
            out_fault_reg <= res_fault;
            out_full_reg  <= res_full;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.frame      = out_frame_reg;
    assign rsp.fault      = out_fault_reg;
    assign rsp.table_full = out_full_reg;

`ifndef SYNTHESIS
    // Pool count never passes the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(POOL_TABLES))
        else $error("pool count beyond pool size");

    // Pool count moves only upward by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + USED_W'(1)))
        else $error("pool count jumped");

    // Full is reported only with the pool exhausted
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_full) |-> !pool_free)
        else $error("table_full with free tables");

    // No second-level write while a lookup read waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_L2) |-> !l2_wr_en)
        else $error("second-level write during lookup");

    // Second-level read only follows a first-level stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_L2) |-> ($past(state_reg) == ST_L1 || $past(state_reg) == ST_L2))
        else $error("second-level stage entered out of order");
`endif

endmodule
